### rtl/core/pet_pkg.sv
// ----------------------------------------------------------------------------
// pet_pkg: shared types, codes and character classes
// Token kinds, scan modes, the transaction payload structs and the small
// character-class helpers used by the #if expression tokenizer.
// ----------------------------------------------------------------------------
package pet_pkg;

	// Line length limit; positions saturate here
	localparam int unsigned MAX_LINE = 4096;
	localparam int unsigned POS_W    = $clog2(MAX_LINE);
	localparam int unsigned LEN_W    = POS_W + 1;
	localparam int unsigned NRES     = 3;

	// Carriage return
	localparam logic [7:0] CH_CR = 8'h0D;

	// Scan modes
	localparam logic [3:0] M_IDLE    = 4'd0;
	localparam logic [3:0] M_IDENT   = 4'd1;
	localparam logic [3:0] M_ZERO    = 4'd2;
	localparam logic [3:0] M_ZERO_B  = 4'd3;
	localparam logic [3:0] M_BIN     = 4'd4;
	localparam logic [3:0] M_ZERO_X  = 4'd5;
	localparam logic [3:0] M_HEX     = 4'd6;
	localparam logic [3:0] M_OCT     = 4'd7;
	localparam logic [3:0] M_DEC     = 4'd8;
	localparam logic [3:0] M_DISCARD = 4'd9;
	localparam logic [3:0] M_OP      = 4'd10;

	// Pending operator / backslash
	localparam logic [2:0] P_NONE = 3'd0;
	localparam logic [2:0] P_BAR  = 3'd1;
	localparam logic [2:0] P_AMP  = 3'd2;
	localparam logic [2:0] P_LT   = 3'd3;
	localparam logic [2:0] P_GT   = 3'd4;
	localparam logic [2:0] P_HASH = 3'd5;
	localparam logic [2:0] P_BSL  = 3'd6;

	// Token kinds
	localparam logic [4:0] K_LPAREN    = 5'd0;
	localparam logic [4:0] K_RPAREN    = 5'd1;
	localparam logic [4:0] K_OR        = 5'd2;
	localparam logic [4:0] K_BITOR     = 5'd3;
	localparam logic [4:0] K_AND       = 5'd4;
	localparam logic [4:0] K_BITAND    = 5'd5;
	localparam logic [4:0] K_NOT       = 5'd6;
	localparam logic [4:0] K_LT        = 5'd7;
	localparam logic [4:0] K_LE        = 5'd8;
	localparam logic [4:0] K_GT        = 5'd9;
	localparam logic [4:0] K_GE        = 5'd10;
	localparam logic [4:0] K_STRINGIZE = 5'd11;
	localparam logic [4:0] K_CONCAT    = 5'd12;
	localparam logic [4:0] K_DEFINED   = 5'd13;
	localparam logic [4:0] K_IDENT     = 5'd14;
	localparam logic [4:0] K_DEC       = 5'd15;
	localparam logic [4:0] K_OCT       = 5'd16;
	localparam logic [4:0] K_HEX       = 5'd17;
	localparam logic [4:0] K_BIN       = 5'd18;
	localparam logic [4:0] K_PUNCT     = 5'd19;
	localparam logic [4:0] K_EOL       = 5'd20;
	localparam logic [4:0] K_BAD       = 5'd21;

	// Keyword matcher
	localparam logic [3:0] KW_LEN  = 4'd7;
	localparam logic [3:0] KW_MISS = 4'd15;

	typedef struct packed {
		logic [7:0] ch;
		logic       end_of_buffer;
	} char_t;

	typedef struct packed {
		logic [4:0]       token_kind;
		logic [POS_W-1:0] token_start;
		logic [LEN_W-1:0] token_length;
		logic             run_last;
	} token_t;

	function automatic logic is_dig(input logic [7:0] c);
		return (c >= "0") && (c <= "9");
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
	endfunction

	function automatic logic is_hexd(input logic [7:0] c);
		return is_dig(c) || ((c >= "a") && (c <= "f")) || ((c >= "A") && (c <= "F"));
	endfunction

	function automatic logic is_idch(input logic [7:0] c);
		return is_alpha(c) || is_dig(c) || (c == "_");
	endfunction

	// Characters that close a numeric literal
	function automatic logic is_term(input logic [7:0] c);
		logic r;
		case (c)
			" ", "\t", "\n", CH_CR, "(", ")", "{", "}", "[", "]", "+", "-", "*",
			"/", "<", ">", "=", "#", "&", "|", "!", "\\": r = 1'b1;
			default: r = 1'b0;
		endcase
		return r;
	endfunction

	// Letters of the keyword "defined"
	function automatic logic [7:0] kw_char(input logic [2:0] idx);
		logic [7:0] r;
		case (idx)
			3'd0: r = "d";
			3'd1: r = "e";
			3'd2: r = "f";
			3'd3: r = "i";
			3'd4: r = "n";
			3'd5: r = "e";
			3'd6: r = "d";
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	// Kind of the open token when it is closed by a following character
	function automatic logic [4:0] fin_kind(input logic [3:0] mode, input logic [2:0] pend,
		input logic [3:0] kw, input logic sep);
		logic [4:0] r;
		case (mode)
			M_OP: begin
				case (pend)
					P_BAR:   r = K_BITOR;
					P_AMP:   r = K_BITAND;
					P_LT:    r = K_LT;
					P_GT:    r = K_GT;
					P_HASH:  r = K_STRINGIZE;
					default: r = K_PUNCT;
				endcase
			end
			M_IDENT: r = (kw == KW_LEN) ? K_DEFINED : K_IDENT;
			M_ZERO:  r = K_DEC;
			M_DEC:   r = sep ? K_DEC : K_BAD;
			M_OCT:   r = sep ? K_OCT : K_BAD;
			M_HEX:   r = sep ? K_HEX : K_BAD;
			M_BIN:   r = sep ? K_BIN : K_BAD;
			default: r = K_BAD;
		endcase
		return r;
	endfunction

	// Token length from start to an exclusive end, floored at zero
	function automatic logic [LEN_W-1:0] span(input logic [LEN_W-1:0] e,
		input logic [POS_W-1:0] b);
		logic [LEN_W-1:0] bx;
		bx = {1'b0, b};
		return (e >= bx) ? (e - bx) : '0;
	endfunction

endpackage

### rtl/core/preproc_expression_tokenizer_core.sv
// ----------------------------------------------------------------------------
// preproc_expression_tokenizer_core: #if expression tokenizer
// Scans one character per transaction and delivers the tokens it closes,
// with kind, start offset and length within the logical line.
// ----------------------------------------------------------------------------
// Usage:
//   char_* channel: one source character per transaction, with end_of_buffer
//   set on the last character of the buffer.
//   tok_* channel: tokens in source order; run_last marks the final token
//   caused by one character. A character causes zero to three tokens.
//   Path: a character accepted into the input register loads its tokens
//   into the token bundle that drives tok_valid (input register, then bundle).
//   Throughput: one character per cycle while each character causes at most
//   one token and the receiver keeps tok_ready high. A character that causes
//   several tokens holds the output bundle until each is popped, and the next
//   character waits in the input register until the last of them is taken;
//   with the bundle empty, characters that cause no token pass at full rate.
//   Receiver stall: the bundle holds, the input register fills, and
//   char_ready drops; nothing is lost.
//   Reset: scan state goes idle, line offset and token start return to zero,
//   both registers empty. No clearing pass.
//   A newline not after a backslash, or end_of_buffer, closes the line and restores the reset scan state.
// ----------------------------------------------------------------------------
module preproc_expression_tokenizer_core
	import pet_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   char_valid,
	output logic   char_ready,
	input  char_t  char_data,
	output logic   tok_valid,
	input  logic   tok_ready,
	output token_t tok_data
);

	// Scan state
	logic [3:0]       mode_q;
	logic             sep_q;
	logic [2:0]       pend_q;
	logic [POS_W-1:0] tb_q;
	logic [LEN_W-1:0] lp_q;
	logic [3:0]       kw_q;

	// Input register and token bundle
	logic        vld_s1;
	char_t       ch_s1;
	token_t      tok_s2 [NRES];
	logic [1:0]  cnt_s2;

	// Next-state working variables
	logic [3:0]       m;
	logic             s;
	logic [2:0]       p;
	logic [POS_W-1:0] tb;
	logic [LEN_W-1:0] lp;
	logic [3:0]       kw;
	logic [1:0]       n;
	token_t           rt [NRES];
	logic             rescan, ended, ok, dig, pair, skip, is_open, last;
	logic [7:0]       c;
	logic [4:0]       pk, fk;
	logic [POS_W-1:0] cur_start;
	logic [LEN_W-1:0] end_incl, e;

	logic pop, pop_last, proc;

	assign pop       = tok_valid && tok_ready;
	assign pop_last  = pop && (cnt_s2 == 2'd1);
	assign proc      = vld_s1 && ((cnt_s2 == 2'd0) || pop_last);
	assign char_ready = !vld_s1 || proc;
	assign tok_valid = (cnt_s2 != 2'd0);
	assign tok_data  = tok_s2[0];

	// Position helpers from the current line offset
	assign cur_start = (lp_q < LEN_W'(MAX_LINE)) ? lp_q[POS_W-1:0] : POS_W'(MAX_LINE - 1);
	assign end_incl  = (lp_q < LEN_W'(MAX_LINE)) ? (lp_q + LEN_W'(1)) : LEN_W'(MAX_LINE);

	// One character through the scanner
	always_comb begin
		m    = (mode_q > M_OP) ? M_IDLE : mode_q;
		s    = sep_q;
		p    = pend_q;
		tb   = tb_q;
		lp   = lp_q;
		kw   = kw_q;
		n    = 2'd0;
		for (int i = 0; i < NRES; i++) begin
			rt[i] = '0;
		end
		c      = ch_s1.ch;
		last   = ch_s1.end_of_buffer;
		rescan = 1'b1;
		ended  = 1'b0;
		ok     = 1'b1;
		dig    = 1'b0;
		pair   = 1'b0;
		skip   = 1'b0;
		pk     = K_LPAREN;
		fk     = K_LPAREN;
		e      = end_incl;

		// Feed the open token
		is_open = ((m >= M_IDENT) && (m <= M_DEC)) || (m == M_OP);
		if (is_open) begin
			if (m == M_OP) begin
				if (p == P_BAR && c == "|") begin pair = 1'b1; pk = K_OR; end
				if (p == P_AMP && c == "&") begin pair = 1'b1; pk = K_AND; end
				if (p == P_LT && c == "=") begin pair = 1'b1; pk = K_LE; end
				if (p == P_GT && c == "=") begin pair = 1'b1; pk = K_GE; end
				if (p == P_HASH && c == "#") begin pair = 1'b1; pk = K_CONCAT; end
				if (pair) begin
					rt[n].token_kind   = pk;
					rt[n].token_start  = tb;
					rt[n].token_length = span(end_incl, tb);
					n = n + 2'd1;
					m = M_IDLE;
					p = P_NONE;
					rescan = 1'b0;
				end
			end else if (m == M_IDENT) begin
				if (is_idch(c)) begin
					if (kw < KW_LEN && c == kw_char(kw[2:0])) begin
						kw = kw + 4'd1;
					end else begin
						kw = KW_MISS;
					end
					rescan = 1'b0;
				end
			end else if (!is_term(c)) begin
				rescan = 1'b0;
				case (m)
					M_ZERO: begin
						if (c == "b" || c == "B") begin
							m = M_ZERO_B;
						end else if (c == "x" || c == "X") begin
							m = M_ZERO_X;
						end else if (c >= "0" && c <= "7") begin
							m = M_OCT;
							s = 1'b1;
						end else if (c == "'") begin
							m = M_OCT;
							s = 1'b0;
						end else begin
							ok = 1'b0;
						end
					end
					M_ZERO_B: begin
						if (c == "0" || c == "1") begin
							m = M_BIN;
							s = 1'b1;
						end else begin
							ok = 1'b0;
						end
					end
					M_ZERO_X: begin
						if (is_hexd(c)) begin
							m = M_HEX;
							s = 1'b1;
						end else begin
							ok = 1'b0;
						end
					end
					default: begin
						case (m)
							M_BIN:   dig = (c == "0") || (c == "1");
							M_OCT:   dig = (c >= "0") && (c <= "7");
							M_HEX:   dig = is_hexd(c);
							default: dig = is_dig(c);
						endcase
						if (dig) begin
							s = 1'b1;
						end else if (c == "'" && s) begin
							s = 1'b0;
						end else begin
							ok = 1'b0;
						end
					end
				endcase
				if (!ok) begin
					rt[n].token_kind   = K_BAD;
					rt[n].token_start  = tb;
					rt[n].token_length = span(end_incl, tb);
					n = n + 2'd1;
					m = M_DISCARD;
					s = 1'b0;
				end
			end
			// Close the open token before this character
			if (rescan) begin
				fk = fin_kind(m, p, kw, s);
				rt[n].token_kind   = fk;
				rt[n].token_start  = tb;
				rt[n].token_length = span(lp_q, tb);
				n  = n + 2'd1;
				m  = (fk == K_BAD) ? M_DISCARD : M_IDLE;
				p  = P_NONE;
				s  = 1'b0;
				kw = 4'd0;
			end
		end

		// Scan the character from idle or discard
		if (rescan) begin
			if (p == P_BSL) begin
				p = P_NONE;
				if (c == "\n") skip = 1'b1;
			end
			if (!skip) begin
				if (c == "\n") begin
					rt[n].token_kind   = K_EOL;
					rt[n].token_start  = cur_start;
					rt[n].token_length = LEN_W'(1);
					n  = n + 2'd1;
					m  = M_IDLE;
					s  = 1'b0;
					p  = P_NONE;
					tb = '0;
					lp = '0;
					kw = 4'd0;
					ended = 1'b1;
				end else if (c == "\\") begin
					p = P_BSL;
				end else if (m != M_DISCARD) begin
					m = M_IDLE;
					case (c)
						" ", "\t", CH_CR: ;
						"(", ")", "!": begin
							rt[n].token_kind   = (c == "(") ? K_LPAREN :
								(c == ")") ? K_RPAREN : K_NOT;
							rt[n].token_start  = cur_start;
							rt[n].token_length = LEN_W'(1);
							n = n + 2'd1;
						end
						"|", "&", "<", ">", "#": begin
							m  = M_OP;
							tb = cur_start;
							p  = (c == "|") ? P_BAR : (c == "&") ? P_AMP :
								(c == "<") ? P_LT : (c == ">") ? P_GT : P_HASH;
						end
						default: begin
							if (is_alpha(c) || c == "_") begin
								m  = M_IDENT;
								tb = cur_start;
								kw = (c == "d") ? 4'd1 : KW_MISS;
							end else if (c == "0") begin
								m  = M_ZERO;
								tb = cur_start;
							end else if (is_dig(c)) begin
								m  = M_DEC;
								tb = cur_start;
								s  = 1'b1;
							end else begin
								rt[n].token_kind   = K_PUNCT;
								rt[n].token_start  = cur_start;
								rt[n].token_length = LEN_W'(1);
								n = n + 2'd1;
							end
						end
					endcase
				end
			end
		end

		// End of buffer closes the line
		if (last && !ended) begin
			is_open = ((m >= M_IDENT) && (m <= M_DEC)) || (m == M_OP);
			if (is_open && n < 2'd3) begin
				fk = fin_kind(m, p, kw, s);
				rt[n].token_kind   = fk;
				rt[n].token_start  = tb;
				rt[n].token_length = span(e, tb);
				n = n + 2'd1;
			end
			if (n < 2'd3) begin
				rt[n].token_kind   = K_EOL;
				rt[n].token_start  = (e < LEN_W'(MAX_LINE)) ? e[POS_W-1:0] :
					POS_W'(MAX_LINE - 1);
				rt[n].token_length = '0;
				n = n + 2'd1;
			end
			m  = M_IDLE;
			s  = 1'b0;
			p  = P_NONE;
			tb = '0;
			lp = '0;
			kw = 4'd0;
			ended = 1'b1;
		end
		if (!ended) lp = end_incl;

		// Mark the final token of this character
		for (int i = 0; i < NRES; i++) begin
			rt[i].run_last = (n != 2'd0) && (2'(i) == (n - 2'd1));
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (char_ready) begin
			vld_s1 <= char_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (char_valid && char_ready) begin
			ch_s1 <= char_data;
		end
	end

	// Scan state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			sep_q  <= 1'b0;
			pend_q <= P_NONE;
			tb_q   <= '0;
			lp_q   <= '0;
			kw_q   <= 4'd0;
		end else if (proc) begin
			mode_q <= m;
			sep_q  <= s;
			pend_q <= p;
			tb_q   <= tb;
			lp_q   <= lp;
			kw_q   <= kw;
		end
	end

	// Token bundle count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_s2 <= 2'd0;
		end else if (proc && n != 2'd0) begin
			cnt_s2 <= n;
		end else if (pop) begin
			cnt_s2 <= cnt_s2 - 2'd1;
		end
	end

	// Token bundle payload: load, or shift toward the output slot
	always_ff @(posedge clk) begin
		if (proc && n != 2'd0) begin
			for (int i = 0; i < NRES; i++) begin
				tok_s2[i] <= rt[i];
			end
		end else if (pop) begin
			for (int i = 0; i < NRES - 1; i++) begin
				tok_s2[i] <= tok_s2[i+1];
			end
		end
	end

`ifndef ASSERT_OFF
	// run_last appears exactly on the final token left in the bundle
	a_run_last: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid |-> (tok_data.run_last == (cnt_s2 == 2'd1)))
		else $error("run_last does not match bundle position");

	// Token lengths never pass the line limit
	a_len_sat: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid |-> (tok_data.token_length <= LEN_W'(MAX_LINE)))
		else $error("token length beyond line limit");

	// Line offset saturates at the limit
	a_lp_sat: assert property (@(posedge clk) disable iff (!arst_n)
		lp_q <= LEN_W'(MAX_LINE))
		else $error("line offset beyond limit");

	// The last character of a buffer always restarts the line
	a_eob_reset: assert property (@(posedge clk) disable iff (!arst_n)
		(proc && ch_s1.end_of_buffer) |=> (lp_q == '0 && mode_q == M_IDLE))
		else $error("line state not cleared at end of buffer");
`endif

endmodule

### verif/preproc_expression_tokenizer_core_test.sv
// ----------------------------------------------------------------------------
// preproc_expression_tokenizer_core_test: self-checking bench for the tokenizer
// Streams #if expression lines through the core one character per
// transaction: two short directed lines, then random well-formed expression
// lines mixed with noise and broken literals. A bit-accurate scan model
// predicts every token; the token channel is checked in order, field by
// field, under random stalls.
// ----------------------------------------------------------------------------
module preproc_expression_tokenizer_core_test;
	import pet_pkg::*;

	localparam logic [LEN_W-1:0] LINE_LIMIT = LEN_W'(MAX_LINE);
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_LF  = 8'h0A;

	// Scan model plus the queue of tokens still owed by the core
	class token_scoreboard;
		token_t due_tokens[$];
		token_t step_tokens[$];
		logic [3:0]       scan_mode;
		logic             sep_ok;
		logic [2:0]       pend_op;
		logic [POS_W-1:0] tok_begin;
		logic [LEN_W-1:0] line_pos;
		logic [3:0]       kw_idx;
		int               n_checked;
		int               n_errors;
		logic [31:0]      kinds_seen;
		string            keyword;

		function new();
			keyword = "defined";
			n_checked = 0;
			n_errors = 0;
			kinds_seen = '0;
			reset_scan();
		endfunction

		function void reset_scan();
			scan_mode = M_IDLE;
			sep_ok = 1'b0;
			pend_op = P_NONE;
			tok_begin = '0;
			line_pos = '0;
			kw_idx = '0;
		endfunction

		function logic [POS_W-1:0] start_here();
			return (line_pos < LINE_LIMIT) ? line_pos[POS_W-1:0] : '1;
		endfunction

		function logic [LEN_W-1:0] end_here();
			return (line_pos < LINE_LIMIT) ? line_pos + 1'b1 : LINE_LIMIT;
		endfunction

		function logic [LEN_W-1:0] length_to(logic [LEN_W-1:0] e);
			logic [LEN_W-1:0] b;
			b = {1'b0, tok_begin};
			return (e >= b) ? e - b : '0;
		endfunction

		function bit is_digit(logic [7:0] c);
			return c >= "0" && c <= "9";
		endfunction

		function bit is_letter(logic [7:0] c);
			return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
		endfunction

		function bit is_hex_digit(logic [7:0] c);
			return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
		endfunction

		// Characters that legally close a literal
		function bit ends_literal(logic [7:0] c);
			case (c)
				" ", CH_TAB, CH_LF, CH_CR, "(", ")", "{", "}", "[", "]", "+", "-",
				"*", "/", "<", ">", "=", "#", "&", "|", "!", "\\": return 1'b1;
				default: return 1'b0;
			endcase
		endfunction

		function void emit(logic [4:0] kind, logic [POS_W-1:0] start, logic [LEN_W-1:0] len);
			token_t t;
			if (step_tokens.size() < NRES) begin
				t.token_kind = kind;
				t.token_start = start;
				t.token_length = len;
				t.run_last = 1'b0;
				step_tokens = {step_tokens, t};
			end
		endfunction

		function bit token_open();
			return (scan_mode >= M_IDENT && scan_mode <= M_DEC) || scan_mode == M_OP;
		endfunction

		// Close the open token at exclusive end e
		function void close_token(logic [LEN_W-1:0] e);
			logic [4:0] kind;
			case (scan_mode)
				M_OP: begin
					case (pend_op)
						P_BAR:   kind = K_BITOR;
						P_AMP:   kind = K_BITAND;
						P_LT:    kind = K_LT;
						P_GT:    kind = K_GT;
						P_HASH:  kind = K_STRINGIZE;
						default: kind = K_PUNCT;
					endcase
				end
				M_IDENT: kind = (kw_idx == KW_LEN) ? K_DEFINED : K_IDENT;
				M_ZERO:  kind = K_DEC;
				M_DEC:   kind = sep_ok ? K_DEC : K_BAD;
				M_OCT:   kind = sep_ok ? K_OCT : K_BAD;
				M_HEX:   kind = sep_ok ? K_HEX : K_BAD;
				M_BIN:   kind = sep_ok ? K_BIN : K_BAD;
				default: kind = K_BAD;
			endcase
			emit(kind, tok_begin, length_to(e));
			scan_mode = (kind == K_BAD) ? M_DISCARD : M_IDLE;
			pend_op = P_NONE;
			sep_ok = 1'b0;
			kw_idx = '0;
		endfunction

		// Offer c to the open token; 1 when c must be scanned again on its own
		function bit continue_token(logic [7:0] c);
			bit paired;
			bit ok;
			bit digit;
			logic [4:0] pair_kind;
			paired = 1'b0;
			ok = 1'b1;
			pair_kind = K_PUNCT;
			if (scan_mode == M_OP) begin
				if (pend_op == P_BAR && c == "|") begin paired = 1'b1; pair_kind = K_OR; end
				if (pend_op == P_AMP && c == "&") begin paired = 1'b1; pair_kind = K_AND; end
				if (pend_op == P_LT && c == "=") begin paired = 1'b1; pair_kind = K_LE; end
				if (pend_op == P_GT && c == "=") begin paired = 1'b1; pair_kind = K_GE; end
				if (pend_op == P_HASH && c == "#") begin paired = 1'b1; pair_kind = K_CONCAT; end
				if (paired) begin
					emit(pair_kind, tok_begin, length_to(end_here()));
					scan_mode = M_IDLE;
					pend_op = P_NONE;
					return 1'b0;
				end
				close_token(line_pos);
				return 1'b1;
			end
			if (scan_mode == M_IDENT) begin
				if (!(is_letter(c) || is_digit(c) || c == "_")) begin
					close_token(line_pos);
					return 1'b1;
				end
				if (kw_idx < KW_LEN && c == keyword[kw_idx])
					kw_idx++;
				else
					kw_idx = KW_MISS;
				return 1'b0;
			end
			if (ends_literal(c)) begin
				close_token(line_pos);
				return 1'b1;
			end
			// literal body
			case (scan_mode)
				M_ZERO: begin
					if (c == "b" || c == "B") scan_mode = M_ZERO_B;
					else if (c == "x" || c == "X") scan_mode = M_ZERO_X;
					else if (c >= "0" && c <= "7") begin scan_mode = M_OCT; sep_ok = 1'b1; end
					else if (c == "'") begin scan_mode = M_OCT; sep_ok = 1'b0; end
					else ok = 1'b0;
				end
				M_ZERO_B: begin
					if (c == "0" || c == "1") begin scan_mode = M_BIN; sep_ok = 1'b1; end
					else ok = 1'b0;
				end
				M_ZERO_X: begin
					if (is_hex_digit(c)) begin scan_mode = M_HEX; sep_ok = 1'b1; end
					else ok = 1'b0;
				end
				default: begin
					if (scan_mode == M_BIN) digit = (c == "0" || c == "1");
					else if (scan_mode == M_OCT) digit = (c >= "0" && c <= "7");
					else if (scan_mode == M_HEX) digit = is_hex_digit(c);
					else digit = is_digit(c);
					if (digit) sep_ok = 1'b1;
					else if (c == "'" && sep_ok) sep_ok = 1'b0;
					else ok = 1'b0;
				end
			endcase
			if (!ok) begin
				emit(K_BAD, tok_begin, length_to(end_here()));
				scan_mode = M_DISCARD;
				sep_ok = 1'b0;
			end
			return 1'b0;
		endfunction

		function void open_op(logic [2:0] p);
			scan_mode = M_OP;
			tok_begin = start_here();
			pend_op = p;
		endfunction

		// Scan c with no token open; 1 when the line has ended
		function bit scan_char(logic [7:0] c);
			if (pend_op == P_BSL) begin
				pend_op = P_NONE;
				if (c == CH_LF) return 1'b0;
			end
			if (c == CH_LF) begin
				emit(K_EOL, start_here(), LEN_W'(1));
				reset_scan();
				return 1'b1;
			end
			if (c == "\\") begin
				pend_op = P_BSL;
				return 1'b0;
			end
			if (scan_mode == M_DISCARD) return 1'b0;
			scan_mode = M_IDLE;
			case (c)
				" ", CH_TAB, CH_CR: ;
				"(": emit(K_LPAREN, start_here(), LEN_W'(1));
				")": emit(K_RPAREN, start_here(), LEN_W'(1));
				"!": emit(K_NOT, start_here(), LEN_W'(1));
				"|": open_op(P_BAR);
				"&": open_op(P_AMP);
				"<": open_op(P_LT);
				">": open_op(P_GT);
				"#": open_op(P_HASH);
				default: begin
					if (is_letter(c) || c == "_") begin
						scan_mode = M_IDENT;
						tok_begin = start_here();
						kw_idx = (c == "d") ? 4'd1 : KW_MISS;
					end else if (c == "0") begin
						scan_mode = M_ZERO;
						tok_begin = start_here();
					end else if (is_digit(c)) begin
						scan_mode = M_DEC;
						tok_begin = start_here();
						sep_ok = 1'b1;
					end else begin
						emit(K_PUNCT, start_here(), LEN_W'(1));
					end
				end
			endcase
			return 1'b0;
		endfunction

		// Accepted character: advance the model, queue the tokens it owes
		function void note_char(char_t d);
			bit rescan;
			bit ended;
			logic [LEN_W-1:0] e;
			token_t t;
			step_tokens.delete();
			rescan = 1'b1;
			ended = 1'b0;
			if (token_open()) rescan = continue_token(d.ch);
			if (rescan) ended = scan_char(d.ch);
			if (d.end_of_buffer && !ended) begin
				e = end_here();
				if (token_open()) close_token(e);
				emit(K_EOL, (e < LINE_LIMIT) ? e[POS_W-1:0] : '1, '0);
				reset_scan();
				ended = 1'b1;
			end
			if (!ended) line_pos = end_here();
			if (step_tokens.size() > 0) begin
				t = step_tokens.pop_back();
				t.run_last = 1'b1;
				step_tokens = {step_tokens, t};
			end
			due_tokens = {due_tokens, step_tokens};
		endfunction

		// Accepted token: compare with the oldest one owed
		function void check_token(token_t got);
			token_t want;
			if (due_tokens.size() == 0) begin
				n_errors++;
				if (n_errors <= 10)
					$display("unexpected token: kind %0d start %0d len %0d last %0b",
						got.token_kind, got.token_start, got.token_length, got.run_last);
				return;
			end
			want = due_tokens.pop_front();
			n_checked++;
			kinds_seen[want.token_kind] = 1'b1;
			if (got.token_kind !== want.token_kind || got.token_start !== want.token_start ||
				got.token_length !== want.token_length || got.run_last !== want.run_last) begin
				n_errors++;
				if (n_errors <= 10)
					$display("token %0d mismatch: want kind %0d start %0d len %0d last %0b, %s%0d %0d %0d %0b",
						n_checked, want.token_kind, want.token_start, want.token_length,
						want.run_last, "got ", got.token_kind, got.token_start,
						got.token_length, got.run_last);
			end
		endfunction
	endclass

	logic   clk = 1'b0;
	logic   arst_n;
	logic   char_valid;
	logic   char_ready;
	char_t  char_data;
	logic   tok_valid;
	logic   tok_ready;
	token_t tok_data;

	token_scoreboard board = new();
	bit          idle_on = 1'b1;
	int          chars_sent = 0;
	logic [7:0]  line_buf[$];
	bit          line_eob;

	string ops_text[11]  = '{"||", "|", "&&", "&", "!", "<", "<=", ">", ">=", "#", "##"};
	string def_forms[6]  = '{"defined", "defined", "define", "definedd", "Defined", "xdefined"};
	string bad_forms[12] = '{"12u", "0x", "0b2", "089", "1'", "1''2", "0xg", "0B", "0'",
		"12ab", "7_", "0b1'"};
	string id_first = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
	string id_rest  = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
	string dec_set  = "0123456789";
	string oct_set  = "01234567";
	string hex_set  = "0123456789abcdefABCDEF";
	string bin_set  = "01";
	string punct_set = ",.'\"?:;%^~@$`{}[]+-*/=";
	string noise_set = "0'xXbB189_dF\\\n#|&<>=! \t";

	preproc_expression_tokenizer_core DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_ready (char_ready),
		.char_data  (char_data),
		.tok_valid  (tok_valid),
		.tok_ready  (tok_ready),
		.tok_data   (tok_data)
	);

	always #2 clk = ~clk;

	// Line construction helpers
	function void add_char(logic [7:0] c);
		line_buf = {line_buf, c};
	endfunction

	function void add_str(string s);
		for (int i = 0; i < s.len(); i++) add_char(s[i]);
	endfunction

	function void add_pick(string s);
		add_char(s[$urandom_range(0, s.len() - 1)]);
	endfunction

	// Digits with an occasional separator, always followed by a digit
	function void add_tail(string s, int n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 4) == 0) add_char("'");
			add_pick(s);
		end
	endfunction

	function void add_token();
		case ($urandom_range(0, 19))
			0, 1: add_char($urandom_range(0, 1) ? 8'h28 : 8'h29);
			2, 3, 4, 5, 16: add_str(ops_text[$urandom_range(0, 10)]);
			6: add_str(def_forms[$urandom_range(0, 5)]);
			7, 8, 15: begin
				add_pick(id_first);
				for (int i = $urandom_range(0, 6); i > 0; i--) add_pick(id_rest);
			end
			9, 10, 17: begin
				if ($urandom_range(0, 3) == 0) begin
					add_char("0");
				end else begin
					add_char(8'("1") + 8'($urandom_range(0, 8)));
					add_tail(dec_set, $urandom_range(0, 5));
				end
			end
			11: begin
				add_char("0");
				add_tail(oct_set, $urandom_range(1, 5));
			end
			12: begin
				add_str($urandom_range(0, 1) ? "0x" : "0X");
				add_pick(hex_set);
				add_tail(hex_set, $urandom_range(0, 5));
			end
			13: begin
				add_str($urandom_range(0, 1) ? "0b" : "0B");
				add_pick(bin_set);
				add_tail(bin_set, $urandom_range(0, 6));
			end
			14: begin
				case ($urandom_range(0, 3))
					0: add_char(8'($urandom_range(128, 255)));
					1: add_char(8'($urandom_range(1, 8)));
					default: add_pick(punct_set);
				endcase
			end
			18: add_char("\\");
			default: add_str(bad_forms[$urandom_range(0, 11)]);
		endcase
	endfunction

	function void add_gap();
		case ($urandom_range(0, 11))
			6: add_char(CH_TAB);
			7: add_char(CH_CR);
			8, 9: ;
			10: add_str("\\\n");
			11: add_str("  ");
			default: add_char(" ");
		endcase
	endfunction

	// Expression line with random content and endings, broken literals included
	function void build_expr_line();
		line_eob = 1'b0;
		for (int i = $urandom_range(1, 8); i > 0; i--) begin
			add_token();
			add_gap();
		end
		case ($urandom_range(0, 11))
			0: begin
				// end of buffer right on an open token
				if (line_buf.size() > 1 && line_buf[line_buf.size() - 1] == " ")
					void'(line_buf.pop_back());
				line_eob = 1'b1;
			end
			1: line_eob = 1'b1;
			2: add_str("\\\n\n");
			3: begin
				add_char(CH_LF);
				line_eob = 1'b1;
			end
			default: add_char(CH_LF);
		endcase
	endfunction

	function void build_noise_line();
		for (int i = $urandom_range(1, 12); i > 0; i--) begin
			if ($urandom_range(0, 1)) add_char(8'($urandom_range(0, 255)));
			else add_pick(noise_set);
		end
		if ($urandom_range(0, 2) == 0) line_eob = 1'b1;
		else begin
			add_char(CH_LF);
			line_eob = 1'b0;
		end
	endfunction

	// One character transaction, with an occasional idle burst before it
	task automatic send_char(input logic [7:0] c, input logic eob);
		char_t d;
		d.ch = c;
		d.end_of_buffer = eob;
		if (idle_on && $urandom_range(0, 9) == 0) begin
			char_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		char_valid <= 1'b1;
		char_data <= d;
		do @(posedge clk); while (!char_ready);
		board.note_char(d);
		chars_sent++;
	endtask

	task automatic send_line(input bit eob_last);
		int n;
		n = line_buf.size();
		for (int i = 0; i < n; i++) send_char(line_buf[i], eob_last && (i == n - 1));
		line_buf.delete();
	endtask

	// Token receiver: ready toggles in random bursts
	initial begin
		int hold;
		tok_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (idle_on && $urandom_range(0, 3) == 0) begin
				tok_ready <= 1'b0;
				hold = $urandom_range(1, 16);
			end else begin
				tok_ready <= 1'b1;
				hold = $urandom_range(1, 24);
			end
			repeat (hold) @(posedge clk);
		end
	end

	// Token monitor
	always @(posedge clk) begin
		if (arst_n && tok_valid && tok_ready) board.check_token(tok_data);
	end

	// Watchdog
	initial begin
		#1000000;
		$display("run did not finish, %0d tokens still owed", board.due_tokens.size());
		$display("Some tests failed");
		$finish;
	end

	// Main sequence
	initial begin
		int stop_at;
		arst_n = 1'b0;
		char_valid = 1'b0;
		char_data = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: keyword, parens, operator pair, hex, compare, binary with separator
		add_str("defined(x)||0x1F<=0b1'0\n");
		send_line(1'b0);
		// high code as punctuation, then end of buffer
		add_char(8'hFF);
		send_line(1'b1);

		// random lines: mostly expressions, some noise
		while (chars_sent < 240) begin
			if ($urandom_range(0, 6) == 0) build_noise_line();
			else build_expr_line();
			send_line(line_eob);
		end

		// closing stretch at full rate on both sides
		idle_on = 1'b0;
		stop_at = chars_sent + 60;
		while (chars_sent < stop_at) begin
			build_expr_line();
			send_line(line_eob);
		end
		char_valid <= 1'b0;

		while (board.due_tokens.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);

		$display("Covered %0d characters and %0d tokens, %0d of 22 token kinds,",
			chars_sent, board.n_checked, $countones(board.kinds_seen));
		$display("including malformed literals, line joins and buffer ends; %0d errors",
			board.n_errors);
		if (board.n_errors == 0 && board.due_tokens.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
